// ===== hdl/qs_pkg.sv =====
// qs_pkg: shared types and constants for the quicksort engine.
// Depends on nothing; used by quicksort_engine and the testbench.
package qs_pkg;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic [10:0]        comparison_count;
    logic               overflow;
  } out_word_t;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  localparam logic REG_PIVOT_MODE = 1'b0;
  localparam logic REG_SEED       = 1'b1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_POP,
    ST_POP_WAIT,
    ST_RND,
    ST_MOD,
    ST_SWAP_RD,
    ST_SWAP_WAIT,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_PIV_RD,
    ST_PIV_WAIT,
    ST_CMP_RD,
    ST_CMP_WAIT,
    ST_CMP_DO,
    ST_CMP_SWAP,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_FIN_WA,
    ST_FIN_WB,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

endpackage

// ===== hdl/qs_ram.sv =====
// qs_ram: generic single-port RAM with registered read.
// Depends on nothing.
module qs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/quicksort_engine.sv =====
// quicksort_engine: top level of the quicksort sorter.
// Depends on qs_pkg and qs_ram.
//
// Values are loaded one word per cycle: a word is taken at an edge where start is
// high and busy is low. A word with last_in high starts an in-place Lomuto
// quicksort over a single-port value RAM, with a second RAM holding the stack of
// index ranges. busy stays high from that edge until the final sorted word has
// been sent. In random pivot mode each range adds an LFSR step, a bitwise
// remainder and the pivot swap. The sorted words then leave on out_valid; the
// receiver cannot stall them. Already ordered input (with the fixed last-element
// pivot) and all-equal input are the slowest cases.
module quicksort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  qs_pkg::in_word_t    in_word,
  output logic                out_valid,
  output qs_pkg::out_word_t   out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = AW + 1;
  localparam int TW = CW + 17;
  localparam logic [2:0] ADDR_PIVOT_MODE = {qs_pkg::REG_PIVOT_MODE, 2'b00};
  localparam logic [2:0] ADDR_SEED       = {qs_pkg::REG_SEED, 2'b00};

  // configuration registers
  logic        pivot_mode;
  logic [15:0] random_seed;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_mode  <= 1'b0;
      random_seed <= 16'd1;
    end else if (cfg_we) begin
      if (paddr == ADDR_PIVOT_MODE) begin
        pivot_mode <= pwdata[0];
      end
      if (paddr == ADDR_SEED) begin
        random_seed <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    case (paddr)
      ADDR_PIVOT_MODE: prdata = {31'd0, pivot_mode};
      ADDR_SEED:       prdata = {16'd0, random_seed};
      default:         prdata = 32'd0;
    endcase
  end

  // state
  qs_pkg::state_t state, state_next;
  logic [CW-1:0]  item_count;
  logic [10:0]    compare_total;
  logic           overflow_seen;
  logic [15:0]    lfsr;
  logic [CW-1:0]  depth;
  logic [AW-1:0]  lo, hi, jj, ii, pp, pick;
  logic           i_valid;          // i = low-1 is represented by i_valid=0
  logic signed [31:0] pivot, tmp_a;
  logic [AW-1:0]  out_k;
  // modulo unit
  logic [15:0]    mod_rem;
  logic [CW-1:0]  mod_size;
  logic [4:0]     mod_bit;

  // value RAM port
  logic          v_we;
  logic [AW-1:0] v_addr;
  logic [31:0]   v_wdata, v_rdata;
  // stack RAM port
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [2*AW-1:0] s_wdata, s_rdata;

  qs_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_vals (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
  qs_ram #(.WIDTH(2*AW), .DEPTH(MAX_ITEMS)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

  logic accept;
  assign busy   = (state != qs_pkg::ST_LOAD);
  assign accept = start && !busy;

  // values stored once the current word lands
  logic [CW-1:0] load_count;
  assign load_count = (item_count < CW'(MAX_ITEMS)) ? item_count + 1'b1 : item_count;

  logic [AW-1:0] ii_next;
  assign ii_next = i_valid ? ii + 1'b1 : lo;
  logic le;
  assign le = $signed(v_rdata) <= pivot;
  logic [15:0] lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ qs_pkg::LFSR_TAPS) : (lfsr >> 1);
  logic [TW-1:0] mod_trial;
  assign mod_trial = TW'(mod_rem) - (TW'(mod_size) << mod_bit);

  // next state and memory port control
  always_comb begin
    state_next = state;
    v_we = 1'b0; v_addr = jj; v_wdata = v_rdata;
    s_we = 1'b0; s_addr = depth[AW-1:0]; s_wdata = {lo, hi};
    case (state)
      qs_pkg::ST_LOAD: begin
        v_addr = item_count[AW-1:0];
        v_wdata = in_word.item_value;
        v_we = accept && item_count < CW'(MAX_ITEMS);
        // first range {0, n-1} goes onto the stack
        s_wdata = {{AW{1'b0}}, AW'(load_count - 1'b1)};
        s_we = accept && in_word.last_in;
        if (accept && in_word.last_in) begin
          state_next = qs_pkg::ST_POP;
        end
      end
      qs_pkg::ST_POP: begin
        s_addr = depth[AW-1:0] - 1'b1;
        state_next = (depth == '0) ? qs_pkg::ST_OUT_RD : qs_pkg::ST_POP_WAIT;
      end
      qs_pkg::ST_POP_WAIT: state_next = pivot_mode ? qs_pkg::ST_RND : qs_pkg::ST_PIV_RD;
      qs_pkg::ST_RND: state_next = qs_pkg::ST_MOD;
      qs_pkg::ST_MOD: if (mod_bit == 5'd0) state_next = qs_pkg::ST_SWAP_RD;
      qs_pkg::ST_SWAP_RD: begin
        v_addr = pick;
        state_next = qs_pkg::ST_SWAP_WAIT;
      end
      qs_pkg::ST_SWAP_WAIT: begin
        v_addr = hi;
        state_next = qs_pkg::ST_SWAP_WA;
      end
      qs_pkg::ST_SWAP_WA: begin
        v_addr = pick; v_we = 1'b1; v_wdata = v_rdata;
        state_next = qs_pkg::ST_SWAP_WB;
      end
      qs_pkg::ST_SWAP_WB: begin
        v_addr = hi; v_we = 1'b1; v_wdata = tmp_a;
        state_next = qs_pkg::ST_PIV_RD;
      end
      qs_pkg::ST_PIV_RD: begin
        v_addr = hi; state_next = qs_pkg::ST_PIV_WAIT;
      end
      qs_pkg::ST_PIV_WAIT: state_next = qs_pkg::ST_CMP_RD;
      qs_pkg::ST_CMP_RD: begin
        v_addr = jj;
        state_next = (jj == hi) ? qs_pkg::ST_FIN_RD : qs_pkg::ST_CMP_WAIT;
      end
      qs_pkg::ST_CMP_WAIT: begin
        // rdata holds a[j]; on a swap fetch a[i+1]
        v_addr = ii_next;
        state_next = le ? qs_pkg::ST_CMP_DO : qs_pkg::ST_CMP_RD;
      end
      qs_pkg::ST_CMP_DO: begin
        // rdata holds a[i+1]; it goes to slot j
        v_addr = jj; v_we = 1'b1; v_wdata = v_rdata;
        state_next = qs_pkg::ST_CMP_SWAP;
      end
      qs_pkg::ST_CMP_SWAP: begin
        // a[j] goes to slot i+1
        v_addr = ii_next; v_we = 1'b1; v_wdata = tmp_a;
        state_next = qs_pkg::ST_CMP_RD;
      end
      qs_pkg::ST_FIN_RD: begin
        v_addr = ii_next; state_next = qs_pkg::ST_FIN_WAIT;
      end
      qs_pkg::ST_FIN_WAIT: begin
        v_addr = ii_next; state_next = qs_pkg::ST_FIN_WA;
      end
      qs_pkg::ST_FIN_WA: begin
        v_addr = hi; v_we = 1'b1; v_wdata = v_rdata;
        state_next = qs_pkg::ST_FIN_WB;
      end
      qs_pkg::ST_FIN_WB: begin
        v_addr = pp; v_we = 1'b1; v_wdata = pivot;
        state_next = qs_pkg::ST_PUSH_R;
      end
      qs_pkg::ST_PUSH_R: begin
        s_wdata = {pp + 1'b1, hi};
        s_we = (pp < hi) && (pp + 1'b1 != hi);
        state_next = qs_pkg::ST_PUSH_L;
      end
      qs_pkg::ST_PUSH_L: begin
        s_wdata = {lo, pp - 1'b1};
        s_we = (pp > lo) && (pp - 1'b1 != lo);
        state_next = qs_pkg::ST_POP;
      end
      qs_pkg::ST_OUT_RD: begin
        v_addr = out_k;
        state_next = (item_count == '0) ? qs_pkg::ST_LOAD : qs_pkg::ST_OUT_EMIT;
      end
      qs_pkg::ST_OUT_EMIT: begin
        v_addr = out_k;
        state_next = (CW'(out_k) + 1'b1 == item_count) ? qs_pkg::ST_LOAD
                                                        : qs_pkg::ST_OUT_RD;
      end
      default: state_next = qs_pkg::ST_LOAD;
    endcase
  end

  // output word
  assign out_valid = (state == qs_pkg::ST_OUT_EMIT);
  always_comb begin
    out_word.sorted_value     = v_rdata;
    out_word.last_out         = (CW'(out_k) + 1'b1 == item_count);
    out_word.comparison_count = compare_total;
    out_word.overflow         = overflow_seen;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= qs_pkg::ST_LOAD;
      item_count    <= '0;
      compare_total <= '0;
      overflow_seen <= 1'b0;
      lfsr          <= 16'd1;
      depth         <= '0;
      out_k         <= '0;
    end else begin
      state <= state_next;
      case (state)
        qs_pkg::ST_LOAD: begin
          if (accept) begin
            if (item_count < CW'(MAX_ITEMS)) item_count <= item_count + 1'b1;
            else overflow_seen <= 1'b1;
            if (in_word.last_in) begin
              lfsr  <= (random_seed == 16'd0) ? 16'd1 : random_seed;
              out_k <= '0;
              // sorting is needed only with two or more stored values
              depth <= (load_count >= CW'(2)) ? CW'(1) : '0;
            end
          end
        end
        qs_pkg::ST_POP: if (depth != '0) depth <= depth - 1'b1;
        qs_pkg::ST_RND: lfsr <= lfsr_step;
        qs_pkg::ST_CMP_WAIT: if (compare_total != qs_pkg::COUNT_MAX)
          compare_total <= compare_total + 1'b1;
        qs_pkg::ST_PUSH_R: if (s_we) depth <= depth + 1'b1;
        qs_pkg::ST_PUSH_L: if (s_we) depth <= depth + 1'b1;
        qs_pkg::ST_OUT_RD: if (item_count == '0) begin
          compare_total <= '0; overflow_seen <= 1'b0;
        end
        qs_pkg::ST_OUT_EMIT: begin
          out_k <= out_k + 1'b1;
          if (CW'(out_k) + 1'b1 == item_count) begin
            item_count <= '0; compare_total <= '0; overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers (no reset)
  always_ff @(posedge clk) begin
    case (state)
      qs_pkg::ST_POP_WAIT: begin
        // range popped from the stack
        {lo, hi} <= s_rdata;
        jj <= s_rdata[2*AW-1:AW];
        i_valid <= 1'b0;
      end
      qs_pkg::ST_RND: begin
        mod_rem  <= lfsr_step;
        mod_size <= CW'(hi - lo) + 1'b1;
        mod_bit  <= 5'd15;
      end
      qs_pkg::ST_MOD: begin
        if (!mod_trial[TW-1]) mod_rem <= mod_trial[15:0];
        if (mod_bit != 5'd0) mod_bit <= mod_bit - 1'b1;
        else pick <= lo + AW'(mod_trial[TW-1] ? mod_rem : mod_trial[15:0]);
      end
      qs_pkg::ST_SWAP_WAIT: tmp_a <= v_rdata;
      qs_pkg::ST_PIV_WAIT: pivot <= v_rdata;
      qs_pkg::ST_CMP_WAIT: begin
        tmp_a <= v_rdata;
        if (!le) jj <= jj + 1'b1;
      end
      qs_pkg::ST_CMP_SWAP: begin
        ii <= ii_next; i_valid <= 1'b1;
        jj <= jj + 1'b1;
      end
      qs_pkg::ST_FIN_RD: pp <= ii_next;
      default: ;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for quicksort_engine (command-style load, strobed output).
// Depends on qs_pkg and quicksort_engine; carries its own quicksort predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int CAP        = 64;
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 100;
  localparam int RANDOM_ITEMS = 100;
  localparam logic [2:0] ADDR_PIVOT_MODE = 3'd0;
  localparam logic [2:0] ADDR_SEED       = 3'd4;

  logic clk, rst, start, busy, out_valid;
  qs_pkg::in_word_t in_word;
  qs_pkg::out_word_t out_word;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  quicksort_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  logic               mode_q;
  logic [15:0]        seed_q;
  logic [15:0]        lfsr_q;
  logic signed [31:0] vals[CAP];
  int                 n_loaded;
  int                 n_compares;
  logic               dropped;

  qs_pkg::in_word_t  pending_words[$];
  qs_pkg::out_word_t sorted_words[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left, burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] lfsr_step();
    logic [15:0] s;
    s = lfsr_q >> 1;
    if (lfsr_q[0]) s = s ^ 16'hB400;
    lfsr_q = s;
    return s;
  endfunction

  function automatic void swap_vals(int a, int b);
    logic signed [31:0] t;
    t = vals[a];
    vals[a] = vals[b];
    vals[b] = t;
  endfunction

  // Lomuto quicksort with an explicit range stack, left part first
  function automatic void sort_set();
    int lo_s[$], hi_s[$];
    int lo, hi, p, i, pick;
    lfsr_q = (seed_q != 0) ? seed_q : 16'd1;
    if (n_loaded < 2) return;
    lo_s.push_back(0);
    hi_s.push_back(n_loaded - 1);
    while (lo_s.size() > 0) begin
      lo = lo_s.pop_back();
      hi = hi_s.pop_back();
      if (mode_q) begin
        pick = lo + int'(32'(lfsr_step()) % (hi - lo + 1));
        swap_vals(pick, hi);
      end
      i = lo - 1;
      for (int j = lo; j < hi; j++) begin
        if (n_compares < 2047) n_compares++;
        if (vals[j] <= vals[hi]) begin
          i++;
          swap_vals(i, j);
        end
      end
      swap_vals(i + 1, hi);
      p = i + 1;
      if (p + 1 < hi) begin
        lo_s.push_back(p + 1);
        hi_s.push_back(hi);
      end
      if (lo < p - 1) begin
        lo_s.push_back(lo);
        hi_s.push_back(p - 1);
      end
    end
  endfunction

  function automatic void predict_word(qs_pkg::in_word_t w);
    qs_pkg::out_word_t r;
    if (n_loaded < CAP) begin
      vals[n_loaded] = w.item_value;
      n_loaded++;
    end else begin
      dropped = 1'b1;
    end
    if (!w.last_in) return;
    sort_set();
    for (int k = 0; k < n_loaded; k++) begin
      r.sorted_value     = vals[k];
      r.last_out         = (k == n_loaded - 1);
      r.comparison_count = 11'(n_compares);
      r.overflow         = dropped;
      sorted_words.push_back(r);
    end
    n_loaded = 0;
    n_compares = 0;
    dropped = 1'b0;
  endfunction

  // Driver: bursts and gaps, one word per accepted edge
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      in_word <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (start && !busy) begin
      predict_word(in_word);
      void'(pending_words.pop_front());
      if (burst_left > 0 && pending_words.size() > 0) begin
        in_word <= pending_words[0];
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        start <= 1'b1;
        in_word <= pending_words[0];
        burst_left <= $urandom_range(0, 12);
      end
    end
  end

  // Monitor: every strobed word against the oldest prediction
  always @(posedge clk) begin
    qs_pkg::out_word_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid) begin
      if (sorted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word);
      end else begin
        e = sorted_words.pop_front();
        if (out_word !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_word);
        end
      end
    end
    if (cycles >= CYCLE_CAP) begin
      $display("[quicksort_engine] ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_PIVOT_MODE) mode_q = d[0];
    else seed_q = d[15:0];
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || sorted_words.size() > 0 || start || busy)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value(int style);
    case (style)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 15))) - 8;
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic queue_set(int len, int style, logic last_on_end);
    qs_pkg::in_word_t w;
    for (int k = 0; k < len; k++) begin
      w.item_value = rand_value(style);
      w.last_in = last_on_end && (k == len - 1);
      pending_words.push_back(w);
    end
  endtask

  initial begin
    qs_pkg::in_word_t w;
    int sent, len;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mode_q = 1'b0; seed_q = 16'd1; lfsr_q = 16'd1;
    n_loaded = 0; n_compares = 0; dropped = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single value, extremes, duplicates, reverse order, store overflow
    w.item_value = 32'sh80000000; w.last_in = 1'b1; pending_words.push_back(w);
    w.item_value = 32'sh7FFFFFFF; w.last_in = 1'b0; pending_words.push_back(w);
    w.item_value = 32'sh80000000; pending_words.push_back(w);
    w.item_value = 0;             pending_words.push_back(w);
    w.item_value = -1;            w.last_in = 1'b1; pending_words.push_back(w);
    for (int k = 5; k >= 0; k--) begin
      w.item_value = k; w.last_in = (k == 0); pending_words.push_back(w);
    end
    drain();
    queue_set(70, 0, 1'b1);   // dropped word carries the last mark
    drain();
    reg_write(ADDR_PIVOT_MODE, 32'd1);
    reg_write(ADDR_SEED, 32'd0);          // zero seed loads as one
    queue_set(8, 3, 1'b1);
    drain();
    reg_write(ADDR_SEED, 32'hFFFF);
    queue_set(64, 2, 1'b1);
    drain();

    // Random sets across several register settings
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      reg_write(ADDR_PIVOT_MODE, 32'(phase % 2));
      reg_write(ADDR_SEED, $urandom());
      for (int s = 0; s < 6; s++) begin
        if (sent < RANDOM_ITEMS) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
          queue_set(len, $urandom_range(0, 3), 1'b1);
          sent += len;
        end
      end
      drain();
      if (sent >= RANDOM_ITEMS) break;
    end

    if (mismatches == 0) begin
      $display("[quicksort_engine] OK");
    end else begin
      $display("[quicksort_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== quicksort_engine.f =====
hdl/qs_pkg.sv
hdl/qs_ram.sv
hdl/quicksort_engine.sv
test/testbench.sv
